// ===== sv/assert_macros.svh =====
// assertion macros shared by the voice allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold on every clock
`define SVA_CHECK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// same-cycle implication
`define SVA_IMPLY(name, clk, rst, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define SVA_NEXT(name, clk, rst, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SVA_CHECK(name, clk, rst, prop)
`define SVA_IMPLY(name, clk, rst, a, c)
`define SVA_NEXT(name, clk, rst, a, c)
`endif
`endif

// ===== sv/svalloc_pkg.sv =====
package svalloc_pkg;

  // key event kinds
  localparam logic [1:0] KS_RELEASED = 2'd0;
  localparam logic [1:0] KS_PRESSED  = 2'd1;
  localparam logic [1:0] KS_HELD     = 2'd2;

  // slot scan kinds
  localparam logic [2:0] K_POLY_MATCH = 3'd0;
  localparam logic [2:0] K_MONO_MATCH = 3'd1;
  localparam logic [2:0] K_FREE       = 3'd2;
  localparam logic [2:0] K_STACK      = 3'd3;
  localparam logic [2:0] K_BEST       = 3'd4;

  // scan start points
  localparam logic [1:0] FROM_ZERO = 2'd0;
  localparam logic [1:0] FROM_ONE  = 2'd1;
  localparam logic [1:0] FROM_PTR  = 2'd2;

  // table update actions
  localparam logic [2:0] A_POLY_HIT    = 3'd0;
  localparam logic [2:0] A_POLY_FREE   = 3'd1;
  localparam logic [2:0] A_MONO_START  = 3'd2;
  localparam logic [2:0] A_STACK_TOP   = 3'd3;
  localparam logic [2:0] A_STACK_NEW   = 3'd4;
  localparam logic [2:0] A_DROP        = 3'd5;
  localparam logic [2:0] A_RELEASE_TOP = 3'd6;

  typedef struct packed {
    logic       load;
    logic       scan_init;
    logic [1:0] start_sel;
    logic       scan_step;
    logic [2:0] kind;
    logic       act_en;
    logic [2:0] act;
  } cmd_t;

  typedef struct packed {
    logic [1:0] item_ks;
    logic       mono;
    logic       slot0_active;
    logic       n0_lt;
    logic       n0_gt;
    logic       hit_now;
    logic       scan_last;
    logic       idx_zero;
  } status_t;

endpackage

// ===== sv/svalloc_dp.sv =====
`include "assert_macros.svh"

module svalloc_dp #(
  parameter int VOICE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic [1:0]           key_state,
  input  logic [6:0]           note_number,
  input  logic [6:0]           note_velocity,
  input  svalloc_pkg::cmd_t    cmd,
  output svalloc_pkg::status_t status,
  output logic                 result_strobe,
  output logic [1:0]           voice_index,
  output logic [1:0]           out_state,
  output logic [6:0]           out_note,
  output logic [6:0]           out_velocity
);

  localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [IW-1:0] LAST = IW'(VOICE_COUNT - 1);
  localparam logic [IW-1:0] LIM1 = IW'((VOICE_COUNT > 1) ? VOICE_COUNT - 2 : 0);
  localparam logic [IW-1:0] ONE  = IW'((VOICE_COUNT > 1) ? 1 : 0);

  logic [1:0]    slot_st   [VOICE_COUNT];
  logic [6:0]    slot_note [VOICE_COUNT];
  logic [6:0]    slot_vel  [VOICE_COUNT];
  logic [IW-1:0] next_slot;
  logic          mono;

  logic [1:0]    item_ks;
  logic [6:0]    item_note;
  logic [6:0]    item_vel;

  logic [IW-1:0] idx;
  logic [IW-1:0] cnt;
  logic          found;
  logic [IW-1:0] hit_idx;
  logic [6:0]    best_note;
  logic [6:0]    best_vel;

  logic [1:0]    cur_st;
  logic [6:0]    cur_note;
  logic          hit;

  // update decode
  logic          wa_en;
  logic          wa_st_only;
  logic [IW-1:0] wa_idx;
  logic [1:0]    wa_st;
  logic [6:0]    wa_note;
  logic [6:0]    wa_vel;
  logic          wz_en;
  logic [1:0]    wz_st;
  logic [6:0]    wz_note;
  logic [6:0]    wz_vel;
  logic          ptr_we;
  logic [IW-1:0] ptr_next;
  logic          emit;
  logic [IW-1:0] em_idx;
  logic [1:0]    em_st;
  logic [6:0]    em_note;
  logic [6:0]    em_vel;
  logic [IW-1:0] free_p;
  logic [IW+1:0] em_wide;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    return (v == LAST) ? '0 : v + IW'(1);
  endfunction

  assign cur_st   = slot_st[idx];
  assign cur_note = slot_note[idx];

  always_comb begin
    hit = 1'b0;
    unique case (cmd.kind)
      svalloc_pkg::K_POLY_MATCH:
        hit = (cur_st == svalloc_pkg::KS_PRESSED) && (cur_note == item_note);
      svalloc_pkg::K_MONO_MATCH:
        hit = (cur_st != svalloc_pkg::KS_RELEASED) && (cur_note == item_note);
      svalloc_pkg::K_FREE:  hit = (cur_st != svalloc_pkg::KS_PRESSED);
      svalloc_pkg::K_STACK: hit = (cur_st == svalloc_pkg::KS_RELEASED);
      svalloc_pkg::K_BEST:
        hit = (cur_st == svalloc_pkg::KS_HELD) && (!found || (cur_note > best_note));
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    status.item_ks      = item_ks;
    status.mono         = mono;
    status.slot0_active = (slot_st[0] == svalloc_pkg::KS_PRESSED) ||
                          (slot_st[0] == svalloc_pkg::KS_HELD);
    status.n0_lt        = slot_note[0] < item_note;
    status.n0_gt        = slot_note[0] > item_note;
    status.hit_now      = hit;
    status.idx_zero     = (idx == '0);
    if ((cmd.kind == svalloc_pkg::K_STACK) || (cmd.kind == svalloc_pkg::K_BEST)) begin
      status.scan_last = (cnt == LIM1);
    end else begin
      status.scan_last = (cnt == LAST);
    end
  end

  // scan unit: one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.scan_init) begin
      found <= 1'b0;
    end else if (cmd.scan_step && hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cnt <= '0;
      unique case (cmd.start_sel)
        svalloc_pkg::FROM_ONE: idx <= ONE;
        svalloc_pkg::FROM_PTR: idx <= next_slot;
        default:               idx <= '0;
      endcase
    end else if (cmd.scan_step) begin
      cnt <= cnt + IW'(1);
      idx <= wrap_inc(idx);
      if (hit) begin
        hit_idx   <= idx;
        best_note <= cur_note;
        best_vel  <= slot_vel[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_ks   <= key_state;
      item_note <= note_number;
      item_vel  <= note_velocity;
    end
  end

  assign free_p = found ? hit_idx : next_slot;

  always_comb begin
    wa_en      = 1'b0;
    wa_st_only = 1'b0;
    wa_idx     = hit_idx;
    wa_st      = item_ks;
    wa_note    = item_note;
    wa_vel     = item_vel;
    wz_en      = 1'b0;
    wz_st      = svalloc_pkg::KS_HELD;
    wz_note    = item_note;
    wz_vel     = item_vel;
    ptr_we     = 1'b0;
    ptr_next   = wrap_inc(free_p);
    emit       = 1'b0;
    em_idx     = '0;
    em_st      = item_ks;
    em_note    = item_note;
    em_vel     = item_vel;
    if (cmd.act_en) begin
      unique case (cmd.act)
        svalloc_pkg::A_POLY_HIT: begin
          wa_en  = 1'b1;
          emit   = 1'b1;
          em_idx = hit_idx;
        end
        svalloc_pkg::A_POLY_FREE: begin
          wa_en  = 1'b1;
          wa_idx = free_p;
          ptr_we = 1'b1;
          emit   = 1'b1;
          em_idx = free_p;
        end
        svalloc_pkg::A_MONO_START: begin
          wz_en = 1'b1;
          wz_st = svalloc_pkg::KS_PRESSED;
          emit  = 1'b1;
          em_st = svalloc_pkg::KS_PRESSED;
        end
        svalloc_pkg::A_STACK_TOP: begin
          // old top note moves down to the stack
          wa_en   = found;
          wa_st   = svalloc_pkg::KS_HELD;
          wa_note = slot_note[0];
          wa_vel  = slot_vel[0];
          wz_en   = 1'b1;
          emit    = 1'b1;
          em_st   = svalloc_pkg::KS_HELD;
        end
        svalloc_pkg::A_STACK_NEW: begin
          wa_en = found;
          wa_st = svalloc_pkg::KS_HELD;
        end
        svalloc_pkg::A_DROP: begin
          wa_en = 1'b1;
          wa_st = svalloc_pkg::KS_RELEASED;
        end
        svalloc_pkg::A_RELEASE_TOP: begin
          wz_en = 1'b1;
          emit  = 1'b1;
          if (found) begin
            // highest stacked note takes over voice 0
            wa_en      = 1'b1;
            wa_st_only = 1'b1;
            wa_st      = svalloc_pkg::KS_RELEASED;
            wz_note    = best_note;
            wz_vel     = best_vel;
            em_st      = svalloc_pkg::KS_HELD;
            em_note    = best_note;
            em_vel     = best_vel;
          end else begin
            wz_st = svalloc_pkg::KS_RELEASED;
            em_st = svalloc_pkg::KS_RELEASED;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        slot_st[i] <= svalloc_pkg::KS_RELEASED;
      end
    end else begin
      if (wa_en) begin
        slot_st[wa_idx] <= wa_st;
      end
      if (wz_en) begin
        slot_st[0] <= wz_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wa_en && !wa_st_only) begin
      slot_note[wa_idx] <= wa_note;
      slot_vel[wa_idx]  <= wa_vel;
    end
    if (wz_en) begin
      slot_note[0] <= wz_note;
      slot_vel[0]  <= wz_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= '0;
      mono      <= 1'b0;
    end else begin
      if (ptr_we) begin
        next_slot <= ptr_next;
      end
      if (cfg_we) begin
        mono <= cfg_wdata;
      end
    end
  end

  assign em_wide = {2'b00, em_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      voice_index  <= em_wide[1:0];
      out_state    <= em_st;
      out_note     <= em_note;
      out_velocity <= em_vel;
    end
  end

  `SVA_CHECK(a_ptr_range, clk, rst, next_slot <= LAST)
  `SVA_IMPLY(a_strobe_from_act, clk, rst, result_strobe, $past(cmd.act_en))
  `SVA_IMPLY(a_hit_range, clk, rst, found, hit_idx <= LAST)

endmodule

// ===== sv/svalloc_ctrl.sv =====
`include "assert_macros.svh"

module svalloc_ctrl #(
  parameter int VOICE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  svalloc_pkg::status_t status,
  output svalloc_pkg::cmd_t    cmd,
  output logic                 busy
);

  localparam bit HAS_STACK = (VOICE_COUNT > 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_ACT    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [2:0] kind;
  logic [2:0] kind_next;
  logic [2:0] act;
  logic [2:0] act_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    act_next      = act;
    cmd.load      = 1'b0;
    cmd.scan_init = 1'b0;
    cmd.start_sel = svalloc_pkg::FROM_ZERO;
    cmd.scan_step = 1'b0;
    cmd.kind      = kind;
    cmd.act_en    = 1'b0;
    cmd.act       = act;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if ((status.item_ks != svalloc_pkg::KS_PRESSED) &&
            (status.item_ks != svalloc_pkg::KS_RELEASED)) begin
          state_next = S_IDLE;
        end else if (!status.mono) begin
          cmd.scan_init = 1'b1;
          kind_next     = svalloc_pkg::K_POLY_MATCH;
          state_next    = S_SCAN;
        end else if (status.item_ks == svalloc_pkg::KS_RELEASED) begin
          cmd.scan_init = 1'b1;
          kind_next     = svalloc_pkg::K_MONO_MATCH;
          state_next    = S_SCAN;
        end else if (!status.slot0_active) begin
          act_next   = svalloc_pkg::A_MONO_START;
          state_next = S_ACT;
        end else if (status.n0_lt || status.n0_gt) begin
          cmd.scan_init = 1'b1;
          cmd.start_sel = svalloc_pkg::FROM_ONE;
          kind_next     = svalloc_pkg::K_STACK;
          act_next      = status.n0_lt ? svalloc_pkg::A_STACK_TOP : svalloc_pkg::A_STACK_NEW;
          state_next    = HAS_STACK ? S_SCAN : S_ACT;
        end else begin
          // press of the sounding note
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        unique case (kind)
          svalloc_pkg::K_POLY_MATCH: begin
            if (status.hit_now) begin
              act_next   = svalloc_pkg::A_POLY_HIT;
              state_next = S_ACT;
            end else if (status.scan_last) begin
              if (status.item_ks == svalloc_pkg::KS_RELEASED) begin
                state_next = S_IDLE;
              end else begin
                cmd.scan_step = 1'b0;
                cmd.scan_init = 1'b1;
                cmd.start_sel = svalloc_pkg::FROM_PTR;
                kind_next     = svalloc_pkg::K_FREE;
              end
            end
          end
          svalloc_pkg::K_FREE: begin
            if (status.hit_now || status.scan_last) begin
              act_next   = svalloc_pkg::A_POLY_FREE;
              state_next = S_ACT;
            end
          end
          svalloc_pkg::K_STACK: begin
            if (status.hit_now || status.scan_last) begin
              state_next = S_ACT;
            end
          end
          svalloc_pkg::K_MONO_MATCH: begin
            if (status.hit_now) begin
              if (status.idx_zero) begin
                // top note released: look for the highest stacked note
                cmd.scan_step = 1'b0;
                cmd.scan_init = 1'b1;
                cmd.start_sel = svalloc_pkg::FROM_ONE;
                kind_next     = svalloc_pkg::K_BEST;
                act_next      = svalloc_pkg::A_RELEASE_TOP;
                state_next    = HAS_STACK ? S_SCAN : S_ACT;
              end else begin
                act_next   = svalloc_pkg::A_DROP;
                state_next = S_ACT;
              end
            end else if (status.scan_last) begin
              state_next = S_IDLE;
            end
          end
          svalloc_pkg::K_BEST: begin
            if (status.scan_last) begin
              act_next   = svalloc_pkg::A_RELEASE_TOP;
              state_next = S_ACT;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
        cmd.kind = kind;
      end
      S_ACT: begin
        cmd.act_en = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= svalloc_pkg::K_POLY_MATCH;
      act   <= svalloc_pkg::A_POLY_HIT;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      act   <= act_next;
    end
  end

  `SVA_NEXT(a_accept_decide, clk, rst, start && !busy, state == S_DECIDE)
  `SVA_NEXT(a_act_idle, clk, rst, state == S_ACT, state == S_IDLE)
  `SVA_IMPLY(a_one_scan_cmd, clk, rst, cmd.scan_init, !cmd.scan_step)

endmodule

// ===== sv/synth_voice_allocator.sv =====
// sequence: load, decide state, optional scans, act state, then the registered result strobe
// polyphonic: match scan, then round-robin free scan
// monophonic: no scan for a first press; other items may run a stack or release scan
// throughput: one item at a time, paced by the one-slot-per-cycle scan
// results are one-cycle strobes and cannot be stalled; busy while working
// rst (sync, active high) releases all slots, clears the pointer and selects polyphonic mode
module synth_voice_allocator #(
  parameter int VOICE_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic [1:0] key_state,
  input  logic [6:0] note_number,
  input  logic [6:0] note_velocity,
  output logic       result_strobe,
  output logic [1:0] voice_index,
  output logic [1:0] out_state,
  output logic [6:0] out_note,
  output logic [6:0] out_velocity
);

  svalloc_pkg::cmd_t    cmd;
  svalloc_pkg::status_t status;

  svalloc_ctrl #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  svalloc_dp #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .key_state     (key_state),
    .note_number   (note_number),
    .note_velocity (note_velocity),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .voice_index   (voice_index),
    .out_state     (out_state),
    .out_note      (out_note),
    .out_velocity  (out_velocity)
  );

endmodule

// ===== tb/voice_event_checker.sv =====
`timescale 1ns / 100ps

module voice_event_checker #(
  parameter int VOICES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic [1:0] key_state,
  input  logic [6:0] note_number,
  input  logic [6:0] note_velocity,
  input  logic       result_strobe,
  input  logic [1:0] voice_index,
  input  logic [1:0] out_state,
  input  logic [6:0] out_note,
  input  logic [6:0] out_velocity,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [1:0] st;
    logic [6:0] note;
    logic [6:0] vel;
  } slot_t;

  typedef struct packed {
    logic [1:0] voice;
    logic [1:0] st;
    logic [6:0] note;
    logic [6:0] vel;
  } voice_evt_t;

  slot_t      slots [VOICES];
  int         next_slot;
  logic       mono;
  voice_evt_t pending_events [$];

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // lower note goes to the first released slot above voice 0, dropped if none
  function automatic void hold_note(input logic [6:0] note, input logic [6:0] vel);
    bit done;
    done = 1'b0;
    for (int i = 1; i < VOICES; i++) begin
      if (!done && slots[i].st == svalloc_pkg::KS_RELEASED) begin
        slots[i] = '{st: svalloc_pkg::KS_HELD, note: note, vel: vel};
        done = 1'b1;
      end
    end
  endfunction

  function automatic bit route_key(input logic [1:0] ks, input logic [6:0] note,
                                   input logic [6:0] vel, output voice_evt_t evt);
    int         hit;
    int         p;
    int         best;
    bit         found;
    logic [6:0] n0;
    logic [6:0] bnote;
    logic [6:0] bvel;
    evt = '0;
    hit = -1;
    if (ks != svalloc_pkg::KS_PRESSED && ks != svalloc_pkg::KS_RELEASED) return 1'b0;
    if (!mono) begin
      for (int i = 0; i < VOICES; i++) begin
        if (hit < 0 && slots[i].st == svalloc_pkg::KS_PRESSED && slots[i].note == note)
          hit = i;
      end
      if (hit >= 0) begin
        slots[hit] = '{st: ks, note: note, vel: vel};
        evt = '{voice: 2'(hit), st: ks, note: note, vel: vel};
        return 1'b1;
      end
      if (ks == svalloc_pkg::KS_RELEASED) return 1'b0;
      // round-robin search; with every slot pressed it wraps back to the pointer
      p = next_slot;
      for (int i = 0; i < VOICES && slots[p].st == svalloc_pkg::KS_PRESSED; i++)
        p = (p + 1) % VOICES;
      slots[p] = '{st: ks, note: note, vel: vel};
      next_slot = (p + 1) % VOICES;
      evt = '{voice: 2'(p), st: ks, note: note, vel: vel};
      return 1'b1;
    end
    if (ks == svalloc_pkg::KS_PRESSED) begin
      if (slots[0].st == svalloc_pkg::KS_PRESSED || slots[0].st == svalloc_pkg::KS_HELD) begin
        n0 = slots[0].note;
        if (n0 < note) begin
          hold_note(n0, slots[0].vel);
          slots[0] = '{st: svalloc_pkg::KS_HELD, note: note, vel: vel};
          evt = '{voice: 2'd0, st: svalloc_pkg::KS_HELD, note: note, vel: vel};
          return 1'b1;
        end
        if (n0 > note) hold_note(note, vel);
        return 1'b0;
      end
      slots[0] = '{st: svalloc_pkg::KS_PRESSED, note: note, vel: vel};
      evt = '{voice: 2'd0, st: svalloc_pkg::KS_PRESSED, note: note, vel: vel};
      return 1'b1;
    end
    for (int i = 0; i < VOICES; i++) begin
      if (hit < 0 && slots[i].st != svalloc_pkg::KS_RELEASED && slots[i].note == note)
        hit = i;
    end
    if (hit < 0) return 1'b0;
    if (hit != 0) begin
      slots[hit] = '{st: svalloc_pkg::KS_RELEASED, note: note, vel: vel};
      return 1'b0;
    end
    // sounding note let go: highest stacked note takes over, lowest slot on ties
    found = 1'b0;
    best = 0;
    bnote = '0;
    for (int i = 1; i < VOICES; i++) begin
      if (slots[i].st == svalloc_pkg::KS_HELD && (!found || slots[i].note > bnote)) begin
        found = 1'b1;
        best = i;
        bnote = slots[i].note;
      end
    end
    if (found) begin
      bvel = slots[best].vel;
      slots[best].st = svalloc_pkg::KS_RELEASED;
      slots[0] = '{st: svalloc_pkg::KS_HELD, note: bnote, vel: bvel};
      evt = '{voice: 2'd0, st: svalloc_pkg::KS_HELD, note: bnote, vel: bvel};
      return 1'b1;
    end
    slots[0] = '{st: svalloc_pkg::KS_RELEASED, note: note, vel: vel};
    evt = '{voice: 2'd0, st: svalloc_pkg::KS_RELEASED, note: note, vel: vel};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    voice_evt_t want;
    voice_evt_t fresh;
    if (rst) begin
      for (int i = 0; i < VOICES; i++)
        slots[i] = '{st: svalloc_pkg::KS_RELEASED, note: 7'd0, vel: 7'd0};
      next_slot = 0;
      mono = 1'b0;
      pending_events.delete();
    end else begin
      if (result_strobe) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event: voice %0d state %0d note %0d vel %0d",
                                    voice_index, out_state, out_note, out_velocity));
        end else begin
          want = pending_events.pop_front();
          if (voice_index !== want.voice)
            report_mismatch($sformatf("voice_index %0d, expected %0d", voice_index, want.voice));
          if (out_state !== want.st)
            report_mismatch($sformatf("out_state %0d, expected %0d", out_state, want.st));
          if (out_note !== want.note)
            report_mismatch($sformatf("out_note %0d, expected %0d", out_note, want.note));
          if (out_velocity !== want.vel)
            report_mismatch($sformatf("out_velocity %0d, expected %0d", out_velocity, want.vel));
        end
      end
      if (cfg_we) mono = cfg_wdata;
      if (start && !busy) begin
        if (route_key(key_state, note_number, note_velocity, fresh))
          pending_events.push_back(fresh);
      end
    end
    pending_count = pending_events.size();
  end

endmodule

// ===== tb/synth_voice_allocator_tb.sv =====
`timescale 1ns / 100ps

module synth_voice_allocator_tb;

  localparam int         VOICE_COUNT = 4;
  localparam int         PHASES      = 10;
  localparam int         PHASE_ITEMS = 200;
  localparam int         POOL_SIZE   = 6;
  localparam logic [1:0] KS_UNKNOWN  = 2'd3;
  localparam logic       MODE_POLY   = 1'b0;
  localparam logic       MODE_MONO   = 1'b1;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic [1:0] key_state = '0;
  logic [6:0] note_number = '0;
  logic [6:0] note_velocity = '0;
  logic       result_strobe;
  logic [1:0] voice_index;
  logic [1:0] out_state;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  int         fail_count;
  int         pending_count;

  synth_voice_allocator #(
    .VOICE_COUNT(VOICE_COUNT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .key_state    (key_state),
    .note_number  (note_number),
    .note_velocity(note_velocity),
    .result_strobe(result_strobe),
    .voice_index  (voice_index),
    .out_state    (out_state),
    .out_note     (out_note),
    .out_velocity (out_velocity)
  );

  voice_event_checker #(
    .VOICES(VOICE_COUNT)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .key_state    (key_state),
    .note_number  (note_number),
    .note_velocity(note_velocity),
    .result_strobe(result_strobe),
    .voice_index  (voice_index),
    .out_state    (out_state),
    .out_note     (out_note),
    .out_velocity (out_velocity),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // start stays high across back-to-back items, dropped for a gap or by drain_events
  task automatic send_key(input logic [1:0] ks, input logic [6:0] note,
                          input logic [6:0] vel, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    key_state <= ks;
    note_number <= note;
    note_velocity <= vel;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every event has come out and the scan unit is quiet
  task automatic drain_events();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (2 * VOICE_COUNT + 4) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [6:0] pool [POOL_SIZE];
    logic [1:0] ks;
    logic [6:0] note;
    int         pick;
    bit         gaps;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // polyphonic: extremes, retrigger, stray release, ignored states, full table
    set_mode(MODE_POLY);
    send_key(svalloc_pkg::KS_PRESSED, 7'd0, 7'd127, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd127, 7'd0, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd127, 7'd5, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd0, 7'd127, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd42, 7'd9, 1'b1);
    send_key(svalloc_pkg::KS_HELD, 7'd10, 7'd10, 1'b1);
    send_key(KS_UNKNOWN, 7'd85, 7'd85, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd20, 7'd1, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd21, 7'd2, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd22, 7'd3, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd23, 7'd4, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd127, 7'd6, 1'b1);
    drain_events();

    // monophonic on a full table: dropped stack, then takeover and tie cases
    set_mode(MODE_MONO);
    send_key(svalloc_pkg::KS_PRESSED, 7'd60, 7'd11, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd23, 7'd12, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd20, 7'd13, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd21, 7'd14, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd60, 7'd15, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd60, 7'd16, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd60, 7'd17, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd70, 7'd18, 1'b1);
    send_key(svalloc_pkg::KS_PRESSED, 7'd60, 7'd19, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd70, 7'd20, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd60, 7'd21, 1'b1);
    send_key(svalloc_pkg::KS_RELEASED, 7'd60, 7'd22, 1'b1);
    drain_events();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_mode((ph % 2 == 0) ? MODE_POLY : MODE_MONO);
      // small note pool per phase so presses and releases pair up
      for (int k = 0; k < POOL_SIZE; k++) pool[k] = 7'($urandom_range(0, 127));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        note = pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 50) begin
          ks = svalloc_pkg::KS_PRESSED;
        end else if (pick < 88) begin
          ks = svalloc_pkg::KS_RELEASED;
        end else if (pick < 94) begin
          ks = ($urandom_range(0, 1) == 0) ? svalloc_pkg::KS_HELD : KS_UNKNOWN;
          note = 7'($urandom_range(0, 127));
        end else begin
          ks = ($urandom_range(0, 1) == 0) ? svalloc_pkg::KS_PRESSED : svalloc_pkg::KS_RELEASED;
          note = 7'($urandom_range(0, 127));
        end
        // gaps in the first half of each phase, none in the final phase
        gaps = (ph != PHASES - 1) && (n < PHASE_ITEMS / 2);
        send_key(ks, note, 7'($urandom_range(0, 127)), gaps);
      end
      drain_events();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== synth_voice_allocator.f =====
+incdir+sv
sv/svalloc_pkg.sv
sv/svalloc_dp.sv
sv/svalloc_ctrl.sv
sv/synth_voice_allocator.sv
tb/voice_event_checker.sv
tb/synth_voice_allocator_tb.sv
